// ----- rtl/core/audio_block_level_metrics_macros.svh -----
// assertion macros used by the audio block level metrics rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef AUDIO_BLOCK_LEVEL_METRICS_MACROS_SVH
`define AUDIO_BLOCK_LEVEL_METRICS_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ABM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abm assertion failed");
// next-cycle implication
`define ABM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abm assertion failed");
`else
`define ABM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ABM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/abm_pkg.sv -----
// types, step codes and constants of the audio block level meter
// no dependencies
`default_nettype none

package abm_pkg;

    localparam int MAX_BLOCK  = 65536;
    localparam int CNT_W      = 17;
    localparam logic signed [15:0] FULL_NEG = 16'sh8000;
    localparam logic signed [15:0] FULL_POS = 16'sh7fff;

    localparam int MUL_A_W     = 64;
    localparam int MUL_B_W     = 32;
    localparam int DIV_NUM_W   = 41;
    localparam int DIV_DEN_W   = 19;
    localparam int SQRT_ROOT_W = 40;
    localparam int SQRT_REM_W  = 42;
    localparam int ITER_W      = 6;

    localparam logic [ITER_W-1:0] MUL_ITERS  = ITER_W'(MUL_B_W);
    localparam logic [ITER_W-1:0] DIV_ITERS  = ITER_W'(DIV_NUM_W);
    localparam logic [ITER_W-1:0] SQRT_ITERS = ITER_W'(SQRT_ROOT_W);

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_sample;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0]   blk_size;
        logic signed [15:0] low_val;
        logic signed [15:0] high_val;
        logic [15:0]        peak_mag;
        logic [15:0]        ac_peak_mag;
        logic [23:0]        mean_abs_q8;
        logic [23:0]        rms_q8;
        logic [23:0]        ac_rms_q8;
        logic signed [23:0] dc_offset_q8;
        logic [CNT_W-1:0]   clip_total;
    } t_out;

    typedef enum logic [3:0] {
        STEP_MUL_D1   = 4'd0,
        STEP_MUL_D2   = 4'd1,
        STEP_DIV_ACP  = 4'd2,
        STEP_DIV_MEAN = 4'd3,
        STEP_DIV_DC   = 4'd4,
        STEP_MUL_QN   = 4'd5,
        STEP_SQRT_RMS = 4'd6,
        STEP_DIV_RMS  = 4'd7,
        STEP_MUL_VAR  = 4'd8,
        STEP_SQRT_AC  = 4'd9,
        STEP_DIV_AC   = 4'd10
    } t_step;

    localparam t_step STEP_FIRST = STEP_MUL_D1;
    localparam t_step STEP_LAST  = STEP_DIV_AC;

    typedef enum logic [1:0] {
        UNIT_MUL  = 2'd0,
        UNIT_DIV  = 2'd1,
        UNIT_SQRT = 2'd2
    } t_unit;

    typedef struct packed {
        logic  in_ready;
        logic  load;
        logic  iter;
        logic  store;
        logic  out_load;
        t_step step;
    } t_cmd;

    typedef struct packed {
        logic close_fire;
        logic out_free;
    } t_sts;

    function automatic t_unit step_unit(input t_step step);
        t_unit u;
        unique case (step)
            STEP_MUL_D1, STEP_MUL_D2, STEP_MUL_QN, STEP_MUL_VAR: u = UNIT_MUL;
            STEP_SQRT_RMS, STEP_SQRT_AC:                         u = UNIT_SQRT;
            default:                                             u = UNIT_DIV;
        endcase
        return u;
    endfunction

    function automatic logic [ITER_W-1:0] step_iters(input t_step step);
        logic [ITER_W-1:0] n;
        unique case (step_unit(step))
            UNIT_MUL:  n = MUL_ITERS;
            UNIT_SQRT: n = SQRT_ITERS;
            default:   n = DIV_ITERS;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/abm_ctrl.sv -----
// sequencer of the level meter: accumulate, then step through the finish program
// depends on abm_pkg and audio_block_level_metrics_macros.svh
`default_nettype none
`include "audio_block_level_metrics_macros.svh"

module abm_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  abm_pkg::t_sts i_sts,
    output abm_pkg::t_cmd o_cmd
);
    import abm_pkg::*;

    typedef enum logic [4:0] {
        S_ACC   = 5'b00001,
        S_LOAD  = 5'b00010,
        S_RUN   = 5'b00100,
        S_STORE = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    t_step             r_step, n_step;
    logic [ITER_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.step = r_step;
        unique case (r_state)
            S_ACC: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.close_fire) begin
                    n_step  = STEP_FIRST;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = step_iters(r_step);
                n_state    = S_RUN;
            end
            S_RUN: begin
                o_cmd.iter = 1'b1;
                n_cnt      = r_cnt - ITER_W'(1);
                if (r_cnt == ITER_W'(1)) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_step  = t_step'(r_step + 4'd1);
                    n_state = S_LOAD;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_step  <= STEP_FIRST;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
        end
    end

    `ABM_ASSERT_IMP(a_out_load_free, i_clk, i_rst_n, o_cmd.out_load, i_sts.out_free)
    `ABM_ASSERT_IMP(a_run_cnt_live, i_clk, i_rst_n, r_state == S_RUN, r_cnt != '0)
    `ABM_ASSERT_NXT(a_last_to_out, i_clk, i_rst_n, o_cmd.store && (r_step == STEP_LAST), r_state == S_OUT)

endmodule

`default_nettype wire

// ----- rtl/core/abm_datapath.sv -----
// accumulators, shift-add multiplier, restoring divider and digit square root
// depends on abm_pkg
`default_nettype none

module abm_datapath (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    input  abm_pkg::t_in  i_in_data,
    input  wire           i_out_ready,
    input  abm_pkg::t_cmd i_cmd,
    output abm_pkg::t_sts o_sts,
    output logic          o_out_valid,
    output abm_pkg::t_out o_out_data
);
    import abm_pkg::*;

    // block accumulators
    logic [CNT_W-1:0]   r_cnt;
    logic signed [15:0] r_min, r_max;
    logic [15:0]        r_peak;
    logic [CNT_W-1:0]   r_clip;
    logic [32:0]        r_sum;
    logic [31:0]        r_asum;
    logic [46:0]        r_qsum;

    logic [15:0] w_sbits, w_mag;
    logic [31:0] w_sq;
    logic        w_accept, w_close;

    assign w_sbits  = i_in_data.sample;
    assign w_mag    = w_sbits[15] ? (~w_sbits + 16'd1) : w_sbits;
    assign w_sq     = 32'(w_mag) * 32'(w_mag);
    assign w_accept = i_in_valid && i_cmd.in_ready;
    assign w_close  = i_in_data.last_sample || (r_cnt == CNT_W'(MAX_BLOCK - 1));

    assign o_sts.close_fire = w_accept && w_close;
    assign o_sts.out_free   = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_cnt  <= '0;
            r_min  <= FULL_POS;
            r_max  <= FULL_NEG;
            r_peak <= '0;
            r_clip <= '0;
            r_sum  <= '0;
            r_asum <= '0;
            r_qsum <= '0;
        end else if (w_accept) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (i_in_data.sample < r_min) begin
                r_min <= i_in_data.sample;
            end
            if (i_in_data.sample > r_max) begin
                r_max <= i_in_data.sample;
            end
            if (w_mag > r_peak) begin
                r_peak <= w_mag;
            end
            if (i_in_data.sample == FULL_NEG || i_in_data.sample == FULL_POS) begin
                r_clip <= r_clip + CNT_W'(1);
            end
            r_sum  <= r_sum + {{17{w_sbits[15]}}, w_sbits};
            r_asum <= r_asum + 32'(w_mag);
            r_qsum <= r_qsum + 47'(w_sq);
        end
    end

    // finish program operands
    logic        w_neg;
    logic [31:0] w_smag;
    logic [63:0] w_sum64;

    assign w_neg   = r_sum[32];
    assign w_smag  = w_neg ? 32'(-r_sum) : r_sum[31:0];
    assign w_sum64 = {{31{r_sum[32]}}, r_sum};

    logic [33:0]         r_d1, r_d2;
    logic [63:0]         r_v;
    logic [15:0]         r_acp;
    logic [23:0]         r_mean, r_dc, r_rms, r_acrms;

    // unit registers
    logic [MUL_A_W-1:0]     r_ma, r_macc, w_ma0, w_acc0;
    logic [MUL_B_W-1:0]     r_mb, w_mb0;
    logic [DIV_NUM_W-1:0]   r_dnum, w_dnum0;
    logic [DIV_DEN_W-1:0]   r_dden, r_drem, w_dden0;
    logic [SQRT_ROOT_W-1:0] r_sroot;
    logic [SQRT_REM_W-1:0]  r_srem;
    logic [79:0]            r_sx;

    logic [33:0] w_dmax;
    assign w_dmax = (r_d1 > r_d2) ? r_d1 : r_d2;

    always_comb begin
        w_ma0   = '0;
        w_mb0   = 32'(r_cnt);
        w_acc0  = '0;
        w_dnum0 = DIV_NUM_W'(r_sroot);
        w_dden0 = DIV_DEN_W'(r_cnt);
        unique case (i_cmd.step)
            STEP_MUL_D1: begin
                w_ma0  = {{48{r_max[15]}}, r_max};
                w_acc0 = -w_sum64;
            end
            STEP_MUL_D2: begin
                w_ma0  = -{{48{r_min[15]}}, r_min};
                w_acc0 = w_sum64;
            end
            STEP_MUL_QN: begin
                w_ma0 = 64'(r_qsum);
            end
            STEP_MUL_VAR: begin
                w_ma0  = -(64'(w_smag));
                w_mb0  = w_smag;
                w_acc0 = r_v;
            end
            STEP_DIV_ACP: begin
                w_dnum0 = DIV_NUM_W'({w_dmax, 1'b0}) + DIV_NUM_W'(r_cnt);
                w_dden0 = DIV_DEN_W'({r_cnt, 1'b0});
            end
            STEP_DIV_MEAN: begin
                w_dnum0 = DIV_NUM_W'({r_asum, 8'd0});
            end
            STEP_DIV_DC: begin
                // round toward minus infinity for a negative sum
                w_dnum0 = DIV_NUM_W'({w_smag, 8'd0})
                        + (w_neg ? (DIV_NUM_W'(r_cnt) - DIV_NUM_W'(1)) : '0);
            end
            default: begin
            end
        endcase
    end

    // one iteration of the restoring divider
    logic [DIV_DEN_W:0] w_dt;
    logic               w_dge;
    assign w_dt  = {r_drem, r_dnum[DIV_NUM_W-1]};
    assign w_dge = w_dt >= {1'b0, r_dden};

    // one digit of the square root
    logic [SQRT_REM_W+1:0] w_st, w_trial;
    logic                  w_sge;
    assign w_st    = {r_srem, r_sx[79:78]};
    assign w_trial = (SQRT_REM_W + 2)'({r_sroot, 2'b01});
    assign w_sge   = w_st >= w_trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ma    <= w_ma0;
            r_mb    <= w_mb0;
            r_macc  <= w_acc0;
            r_dnum  <= w_dnum0;
            r_dden  <= w_dden0;
            r_drem  <= '0;
            r_sx    <= {r_v, 16'd0};
            r_srem  <= '0;
            r_sroot <= '0;
        end else if (i_cmd.iter) begin
            unique case (step_unit(i_cmd.step))
                UNIT_MUL: begin
                    if (r_mb[0]) begin
                        r_macc <= r_macc + r_ma;
                    end
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb >> 1;
                end
                UNIT_SQRT: begin
                    r_srem  <= w_sge ? SQRT_REM_W'(w_st - w_trial) : w_st[SQRT_REM_W-1:0];
                    r_sroot <= {r_sroot[SQRT_ROOT_W-2:0], w_sge};
                    r_sx    <= r_sx << 2;
                end
                default: begin
                    r_drem <= w_dge ? DIV_DEN_W'(w_dt - {1'b0, r_dden})
                                    : w_dt[DIV_DEN_W-1:0];
                    r_dnum <= {r_dnum[DIV_NUM_W-2:0], w_dge};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            unique case (i_cmd.step)
                STEP_MUL_D1:   r_d1    <= r_macc[33:0];
                STEP_MUL_D2:   r_d2    <= r_macc[33:0];
                STEP_MUL_QN,
                STEP_MUL_VAR:  r_v     <= r_macc;
                STEP_DIV_ACP:  r_acp   <= r_dnum[15:0];
                STEP_DIV_MEAN: r_mean  <= r_dnum[23:0];
                STEP_DIV_DC:   r_dc    <= w_neg ? (~r_dnum[23:0] + 24'd1) : r_dnum[23:0];
                STEP_DIV_RMS:  r_rms   <= r_dnum[23:0];
                STEP_DIV_AC:   r_acrms <= r_dnum[23:0];
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_data.blk_size     <= r_cnt;
            o_out_data.low_val      <= r_min;
            o_out_data.high_val     <= r_max;
            o_out_data.peak_mag     <= r_peak;
            o_out_data.ac_peak_mag  <= r_acp;
            o_out_data.mean_abs_q8  <= r_mean;
            o_out_data.rms_q8       <= r_rms;
            o_out_data.ac_rms_q8    <= r_acrms;
            o_out_data.dc_offset_q8 <= r_dc;
            o_out_data.clip_total   <= r_clip;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/audio_block_level_metrics.sv -----
// audio block level meter: count, min, max, peak, clip count, ac peak, mean abs, rms, dc, ac rms
// samples are taken one per cycle while a block accumulates
// closing sample starts the finish pass (4 multiplies, 5 divides and 2 roots, each loaded, iterated
// and stored in turn), then the output register is loaded
// one output register holds the result; a full one delays the load and stalls the input
// synchronous active-low reset clears the accumulators, the sequencer and the output valid
`default_nettype none

module audio_block_level_metrics (
    input  wire           i_clk,
    input  wire           i_rst_n,
    // sample transactions
    input  wire           i_in_valid,
    output logic          o_in_ready,
    input  abm_pkg::t_in  i_in_data,
    // result transactions
    output logic          o_out_valid,
    input  wire           i_out_ready,
    output abm_pkg::t_out o_out_data
);
    import abm_pkg::*;

    // command and status between sequencer and datapath
    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: accumulate state, then load/iterate/store per finish step
    abm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // datapath: block accumulators, shared arithmetic units, output register
    abm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // samples are only taken while the sequencer accumulates
    assign o_in_ready = w_cmd.in_ready;

endmodule

`default_nettype wire
